FILE: src/sws_pkg.sv
// Shared types and constants for the sliding-window seed trigger.
package sws_pkg;

    localparam int DEFAULT_WINDOW_DEPTH = 64;

    localparam int TIME_W   = 48;
    localparam int DIFF_W   = TIME_W + 1;
    localparam int CFG_W    = 32;
    localparam int DIGI_W   = 7;
    localparam int SEED_W   = 51;
    localparam int CFG_IDX_W = 8;

    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_DURATION = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_MIN_DIGIS       = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_DEAD_TIME       = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_SEED_OFFSET     = CFG_IDX_W'(3);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_EXPIRE,
        ST_FIRE
    } sws_state_t;

    typedef struct packed {
        logic [CFG_W-1:0]  window_duration;
        logic [DIGI_W-1:0] min_digis;
        logic [CFG_W-1:0]  dead_time;
        logic [CFG_W-1:0]  seed_offset;
    } sws_cfg_t;

    // Commands from the sequencer to the row of window cells.
    typedef struct packed {
        logic shift;
        logic wr_en;
    } sws_cell_ctl_t;

endpackage

FILE: src/sliding_window_seed_trigger.sv
// Sliding-window multiplicity trigger with dead time: top level.
//
// Hits enter on s_* (valid/ready), one timestamp per transaction, with
// s_slice_end marking the last hit of a slice. Seeds leave on m_* as
// m_seed_time_half = 2*seed_offset + hit time + window start, in half units.
// Registers are written over cfg_* (index 0 window_duration, 1 min_digis,
// 2 dead_time, 3 seed_offset); cfg_ready is always high, other indexes are
// ignored. Write registers only while the block is idle.
// The window is a row of WINDOW_DEPTH cells with the oldest hit in cell 0;
// dropping an old hit shifts the whole row down by one cell per cycle.
// An item is dropped at the check step when in dead time; otherwise it is
// appended, expired hits go one by one, and a fire step follows for a seed.
// A seed is in the output register in the cycle after its item's last step.
// The output register lets the next hit be taken while a seed waits; a
// second seed waits until the first one is taken.
// Reset clears window count, dead time state and the configuration registers
// to their reset values; the cells need no clearing.
module sliding_window_seed_trigger #(
    parameter int WINDOW_DEPTH = sws_pkg::DEFAULT_WINDOW_DEPTH
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [sws_pkg::TIME_W-1:0]    s_hit_time,
    input  logic                          s_slice_end,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [sws_pkg::SEED_W-1:0]    m_seed_time_half,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [sws_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [sws_pkg::CFG_W-1:0]     cfg_data
);
    import sws_pkg::*;

    localparam int IDX_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;

    sws_cfg_t          cfg_reg, cfg_next;
    sws_cell_ctl_t     cell_ctl;
    logic [IDX_W-1:0]  wr_idx;
    logic [TIME_W-1:0] wr_data;
    logic [TIME_W-1:0] cell_data [WINDOW_DEPTH];

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                REG_WINDOW_DURATION: cfg_next.window_duration = cfg_data;
                REG_MIN_DIGIS:       cfg_next.min_digis       = cfg_data[DIGI_W-1:0];
                REG_DEAD_TIME:       cfg_next.dead_time       = cfg_data;
                REG_SEED_OFFSET:     cfg_next.seed_offset     = cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.window_duration <= '0;
            cfg_reg.min_digis       <= DIGI_W'(1);
            cfg_reg.dead_time       <= '0;
            cfg_reg.seed_offset     <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg_ready = 1'b1;

    sws_ctrl #(
        .WINDOW_DEPTH (WINDOW_DEPTH),
        .IDX_W        (IDX_W)
    ) u_ctrl (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg              (cfg_reg),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_hit_time       (s_hit_time),
        .s_slice_end      (s_slice_end),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_seed_time_half (m_seed_time_half),
        .head_time        (cell_data[0]),
        .cell_ctl         (cell_ctl),
        .wr_idx           (wr_idx),
        .wr_data          (wr_data)
    );

    for (genvar i = 0; i < WINDOW_DEPTH; i++) begin : g_cell
        logic [TIME_W-1:0] upper;
        if (i == WINDOW_DEPTH - 1) begin : g_top
            assign upper = cell_data[i];
        end else begin : g_mid
            assign upper = cell_data[i+1];
        end
        sws_cell u_cell (
            .aclk      (aclk),
            .shift     (cell_ctl.shift),
            .wr_sel    (cell_ctl.wr_en && (wr_idx == IDX_W'(i))),
            .wr_data   (wr_data),
            .next_data (upper),
            .data      (cell_data[i])
        );
    end

endmodule

FILE: src/sws_cell.sv
// One window cell: holds a hit time, takes its upper neighbor's on shift.
module sws_cell (
    input  logic                       aclk,
    input  logic                       shift,
    input  logic                       wr_sel,
    input  logic [sws_pkg::TIME_W-1:0] wr_data,
    input  logic [sws_pkg::TIME_W-1:0] next_data,
    output logic [sws_pkg::TIME_W-1:0] data
);
    import sws_pkg::*;

    logic [TIME_W-1:0] data_reg;
    logic [TIME_W-1:0] data_next;

    always_comb begin
        data_next = data_reg;
        if (wr_sel) begin
            data_next = wr_data;
        end else if (shift) begin
            data_next = next_data;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

FILE: src/sws_ctrl.sv
// Sequencer: dead-time check, append, expiry, seed generation and output register.
module sws_ctrl #(
    parameter int WINDOW_DEPTH = sws_pkg::DEFAULT_WINDOW_DEPTH,
    parameter int IDX_W        = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  sws_pkg::sws_cfg_t           cfg,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [sws_pkg::TIME_W-1:0]  s_hit_time,
    input  logic                        s_slice_end,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [sws_pkg::SEED_W-1:0]  m_seed_time_half,
    input  logic [sws_pkg::TIME_W-1:0]  head_time,
    output sws_pkg::sws_cell_ctl_t      cell_ctl,
    output logic [IDX_W-1:0]            wr_idx,
    output logic [sws_pkg::TIME_W-1:0]  wr_data
);
    import sws_pkg::*;

    localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(WINDOW_DEPTH);
    localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

    sws_state_t         state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               dead_reg, dead_next;
    logic [TIME_W-1:0]  ref_reg, ref_next;
    logic [TIME_W-1:0]  time_reg;
    logic               last_reg;
    logic               m_valid_reg, m_valid_next;
    logic [SEED_W-1:0]  seed_reg;

    logic signed [DIFF_W-1:0] head_diff;
    logic signed [DIFF_W-1:0] dead_diff;
    logic                     expire_hit;
    logic                     dead_over;
    logic                     enough;
    logic                     out_free;
    logic                     load_out;
    logic                     finish;
    logic [SEED_W-1:0]        seed_sum;

    // Differences are signed so that a hit earlier than the reference stays inside.
    assign head_diff  = $signed({1'b0, time_reg}) - $signed({1'b0, head_time});
    assign dead_diff  = $signed({1'b0, time_reg}) - $signed({1'b0, ref_reg});
    assign expire_hit = (count_reg > CNT_ONE)
                     && (head_diff > $signed(DIFF_W'(cfg.window_duration)));
    assign dead_over  = dead_diff > $signed(DIFF_W'(cfg.dead_time));
    assign enough     = 32'(count_reg) >= 32'(cfg.min_digis);
    assign out_free   = !m_valid_reg || m_ready;

    assign seed_sum = {{(SEED_W - CFG_W - 1){cfg.seed_offset[CFG_W-1]}},
                       cfg.seed_offset, 1'b0}
                    + SEED_W'(time_reg) + SEED_W'(head_time);

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (dead_reg && !dead_over) begin
                    state_next = ST_IDLE;
                end else begin
                    state_next = ST_EXPIRE;
                end
            end
            ST_EXPIRE: begin
                if (!expire_hit) begin
                    state_next = enough ? ST_FIRE : ST_IDLE;
                end
            end
            ST_FIRE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Outputs and datapath control
    always_comb begin
        cell_ctl   = '0;
        wr_idx     = '0;
        count_next = count_reg;
        dead_next  = dead_reg;
        ref_next   = ref_reg;
        load_out   = 1'b0;
        finish     = 1'b0;
        case (state_reg)
            ST_IDLE: begin
            end
            ST_CHECK: begin
                if (dead_reg && !dead_over) begin
                    finish = 1'b1;
                end else begin
                    dead_next      = 1'b0;
                    cell_ctl.wr_en = 1'b1;
                    if (count_reg == CNT_FULL) begin
                        // full row: drop the oldest while appending at the top
                        cell_ctl.shift = 1'b1;
                        wr_idx         = IDX_W'(WINDOW_DEPTH - 1);
                    end else begin
                        wr_idx     = count_reg[IDX_W-1:0];
                        count_next = count_reg + CNT_ONE;
                    end
                end
            end
            ST_EXPIRE: begin
                if (expire_hit) begin
                    cell_ctl.shift = 1'b1;
                    count_next     = count_reg - CNT_ONE;
                end else if (!enough) begin
                    finish = 1'b1;
                end
            end
            ST_FIRE: begin
                if (out_free) begin
                    load_out   = 1'b1;
                    count_next = '0;
                    dead_next  = 1'b1;
                    ref_next   = time_reg;
                    finish     = 1'b1;
                end
            end
            default: begin
            end
        endcase
        if (finish && last_reg) begin
            count_next = '0;
            dead_next  = 1'b0;
            ref_next   = '0;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (m_ready) begin
            m_valid_next = 1'b0;
        end
        if (load_out) begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            dead_reg    <= 1'b0;
            ref_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            dead_reg    <= dead_next;
            ref_reg     <= ref_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            time_reg <= s_hit_time;
            last_reg <= s_slice_end;
        end
        if (load_out) begin
            seed_reg <= seed_sum;
        end
    end

    assign s_ready          = (state_reg == ST_IDLE);
    assign m_valid          = m_valid_reg;
    assign m_seed_time_half = seed_reg;
    assign wr_data          = time_reg;

    property p_count_bounded;
        @(posedge aclk) disable iff (!aresetn) count_reg <= CNT_FULL;
    endproperty
    assert property (p_count_bounded) else $error("window count above depth");

    property p_fire_clears;
        @(posedge aclk) disable iff (!aresetn) load_out |=> (count_reg == '0) && m_valid_reg;
    endproperty
    assert property (p_fire_clears) else $error("seed did not clear window");

    property p_expire_keeps_one;
        @(posedge aclk) disable iff (!aresetn)
            (state_reg == ST_EXPIRE && cell_ctl.shift) |-> count_reg > CNT_ONE;
    endproperty
    assert property (p_expire_keeps_one) else $error("expiry emptied the window");

    property p_no_overwrite;
        @(posedge aclk) disable iff (!aresetn) load_out |-> (!m_valid_reg || m_ready);
    endproperty
    assert property (p_no_overwrite) else $error("pending seed overwritten");

endmodule

FILE: test/sliding_window_seed_trigger_test.sv
// Self-checking testbench for the seed trigger: random hit streams against a window predictor.
module sliding_window_seed_trigger_test;
    import sws_pkg::*;

    localparam int DEPTH         = DEFAULT_WINDOW_DEPTH;
    localparam int SETTLE_CYCLES = 2 * DEPTH + 8;
    localparam int HIT_TARGET    = 900;
    localparam int PHASE_CAP     = 30;

    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_LOW = CFG_IDX_W'(4);
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_TOP = '1;
    localparam logic [TIME_W-1:0]    TIME_MAX         = '1;

    typedef struct packed {
        logic [TIME_W-1:0] stamp;
        logic              last;
    } hit_t;

    logic                 aclk             = 1'b0;
    logic                 aresetn          = 1'b0;
    logic                 s_valid          = 1'b0;
    logic                 s_ready;
    logic [TIME_W-1:0]    s_hit_time       = '0;
    logic                 s_slice_end      = 1'b0;
    logic                 m_valid;
    logic                 m_ready          = 1'b0;
    logic [SEED_W-1:0]    m_seed_time_half;
    logic                 cfg_valid        = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index        = '0;
    logic [CFG_W-1:0]     cfg_data         = '0;

    sliding_window_seed_trigger dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_hit_time       (s_hit_time),
        .s_slice_end      (s_slice_end),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_seed_time_half (m_seed_time_half),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    always #2 aclk = ~aclk;

    // Register copies kept by the predictor.
    logic [CFG_W-1:0]        reg_window    = '0;
    logic [DIGI_W-1:0]       reg_min_digis = DIGI_W'(1);
    logic [CFG_W-1:0]        reg_dead      = '0;
    logic signed [CFG_W-1:0] reg_offset    = '0;

    // Window state of the predictor.
    logic [TIME_W-1:0] win_times [DEPTH];
    int                win_count = 0;
    int                win_head  = 0;
    bit                dead_on   = 1'b0;
    logic [TIME_W-1:0] dead_ref  = '0;

    hit_t              pending_hits [$];
    logic [SEED_W-1:0] seeds_due [$];

    hit_t              next_hit;
    logic              next_valid;
    bit                hit_taken  = 1'b0;
    int                hit_gap    = 0;
    int                ready_hold = 0;
    int                calm_left  = 0;
    int                hits_total = 0;
    int                fail_count = 0;
    int                phase_no;
    logic [SEED_W-1:0] seed_want;

    task automatic report_mismatch(input string what);
        $display("[%0t] seed check: %s", $time, what);
        fail_count++;
    endtask

    // Runs one hit through the window and queues the seed it fires, if any.
    task automatic advance_window(input logic [TIME_W-1:0] t, input logic last);
        longint span;
        longint seed;
        bit     skip;
        skip = 1'b0;
        if (dead_on) begin
            span = longint'({16'd0, t}) - longint'({16'd0, dead_ref});
            if (span <= longint'({32'd0, reg_dead}))
                skip = 1'b1;
            else
                dead_on = 1'b0;
        end
        if (!skip) begin
            // full ring: oldest hit goes first
            if (win_count >= DEPTH) begin
                win_head  = (win_head + 1) % DEPTH;
                win_count = DEPTH - 1;
            end
            win_times[(win_head + win_count) % DEPTH] = t;
            win_count++;
            while (win_count > 1 &&
                   longint'({16'd0, t}) - longint'({16'd0, win_times[win_head]}) >
                   longint'({32'd0, reg_window})) begin
                win_head = (win_head + 1) % DEPTH;
                win_count--;
            end
            if (win_count >= int'(reg_min_digis)) begin
                seed = 2 * longint'(reg_offset) + longint'({16'd0, t})
                       + longint'({16'd0, win_times[win_head]});
                seeds_due.insert(seeds_due.size(), seed[SEED_W-1:0]);
                win_count = 0;
                win_head  = 0;
                dead_on   = 1'b1;
                dead_ref  = t;
            end
        end
        if (last) begin
            win_count = 0;
            win_head  = 0;
            dead_on   = 1'b0;
            dead_ref  = '0;
        end
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm_left > 0 || r < 55) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic int pick_slice(input bit long_only);
        int r;
        r = $urandom_range(0, 19);
        if (long_only) return $urandom_range(66, 100);
        if (r == 0) return 1;
        if (r < 4) return $urandom_range(60, 90);
        return $urandom_range(4, 40);
    endfunction

    task automatic push_hit(input logic [TIME_W-1:0] t, input logic last);
        hit_t entry;
        entry.stamp = t;
        entry.last  = last;
        pending_hits.insert(pending_hits.size(), entry);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (cfg_ready !== 1'b1) @(posedge aclk);
        case (idx)
            REG_WINDOW_DURATION: reg_window    = val;
            REG_MIN_DIGIS:       reg_min_digis = val[DIGI_W-1:0];
            REG_DEAD_TIME:       reg_dead      = val;
            REG_SEED_OFFSET:     reg_offset    = val;
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Waits until every hit is taken and every seed is back, then lets the
    // block finish any hit that fires nothing.
    task automatic drain();
        while (pending_hits.size() != 0 || s_valid || seeds_due.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic random_phase(input bit fill_store);
        logic [CFG_W-1:0]  wd;
        logic [CFG_W-1:0]  dt;
        logic [CFG_W-1:0]  off;
        logic [CFG_W-1:0]  span_w;
        logic [DIGI_W-1:0] md;
        logic [TIME_W-1:0] t;
        longint            span;
        int                n;
        int                k;
        int                r;
        int                slice_left;
        logic              last;
        case ($urandom_range(0, 7))
            0:       wd = '0;
            1:       wd = '1;
            2, 3:    wd = $urandom_range(1, 40);
            default: wd = $urandom >> $urandom_range(0, 31);
        endcase
        case ($urandom_range(0, 11))
            0:       md = '0;
            1:       md = DIGI_W'(1);
            2:       md = DIGI_W'(DEPTH);
            3:       md = DIGI_W'($urandom_range(DEPTH + 1, 127));
            4, 5:    md = DIGI_W'($urandom_range(50, DEPTH - 1));
            default: md = DIGI_W'($urandom_range(2, 10));
        endcase
        if (fill_store) begin
            md = DIGI_W'($urandom_range(DEPTH + 1, 127));
            wd = '1;
        end else if (int'(md) > DEPTH && $urandom_range(0, 1) == 0) begin
            wd = '1;
        end
        case ($urandom_range(0, 5))
            0:       dt = '0;
            1:       dt = '1;
            2, 3:    dt = $urandom_range(0, 50);
            default: dt = $urandom >> $urandom_range(0, 31);
        endcase
        case ($urandom_range(0, 4))
            0:       off = 32'h8000_0000;
            1:       off = 32'h7FFF_FFFF;
            2:       off = '0;
            default: off = $urandom;
        endcase
        write_reg(REG_WINDOW_DURATION, wd);
        write_reg(REG_MIN_DIGIS, CFG_W'(md));
        write_reg(REG_DEAD_TIME, dt);
        write_reg(REG_SEED_OFFSET, off);
        if ($urandom_range(0, 3) == 0)
            write_reg($urandom_range(0, 1) ? REG_UNMAPPED_LOW : REG_UNMAPPED_TOP, $urandom);

        // step size scaled so that min_digis hits usually fit in the window
        span = longint'({32'd0, wd}) / longint'(int'(md) + 1) + 1;
        if (span > 64'h0000_0000_FFFF_FFFF) span = 64'h0000_0000_FFFF_FFFF;
        span_w = span[CFG_W-1:0];

        t = TIME_W'({$urandom, $urandom} >> $urandom_range(0, 40));
        n = fill_store ? 150 : $urandom_range(60, 120);
        slice_left = pick_slice(fill_store);
        for (k = 0; k < n; k++) begin
            r = $urandom_range(0, 19);
            case (r)
                0:       t = TIME_W'({$urandom, $urandom});
                1:       t = t - TIME_W'($urandom_range(0, span_w));
                2:       t = t + TIME_W'(dt) + TIME_W'($urandom_range(1, span_w));
                default: t = t + TIME_W'($urandom_range(0, span_w));
            endcase
            slice_left--;
            last = (slice_left <= 0) || ($urandom_range(0, 99) == 0);
            push_hit(t, last);
            if (last) slice_left = pick_slice(fill_store);
        end
    endtask

    // Input side: prediction on each accepted transaction.
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready === 1'b1) begin
            advance_window(s_hit_time, s_slice_end);
            hit_taken = 1'b1;
            hits_total++;
        end
    end

    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (calm_left > 0)
                calm_left--;
            else if ($urandom_range(0, 399) == 0)
                calm_left = $urandom_range(40, 200);
            next_valid = s_valid;
            if (hit_taken) begin
                hit_taken  = 1'b0;
                next_valid = 1'b0;
            end
            if (!next_valid) begin
                if (hit_gap > 0) begin
                    hit_gap--;
                end else if (pending_hits.size() != 0) begin
                    next_hit = pending_hits.pop_front();
                    s_hit_time  <= next_hit.stamp;
                    s_slice_end <= next_hit.last;
                    next_valid = 1'b1;
                    hit_gap    = pick_gap();
                end
            end
            s_valid <= next_valid;
        end
    end

    // Seed side: random backpressure and in-order compare.
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (ready_hold > 0) begin
            ready_hold--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
            if ($urandom_range(0, 2) == 0) ready_hold = pick_gap();
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid === 1'b1 && m_ready) begin
            if (seeds_due.size() == 0) begin
                report_mismatch($sformatf("unexpected seed %h", m_seed_time_half));
            end else begin
                seed_want = seeds_due.pop_front();
                if (m_seed_time_half !== seed_want)
                    report_mismatch($sformatf("seed_time_half got %h want %h",
                                              m_seed_time_half, seed_want));
            end
        end
    end

    initial begin
        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;

        // reset settings: every hit outside the zero dead time fires alone
        push_hit('0, 1'b0);
        push_hit('0, 1'b0);
        push_hit(TIME_W'(1), 1'b0);
        push_hit(TIME_MAX, 1'b1);
        push_hit(TIME_W'(3), 1'b0);
        drain();

        // expiry, dead-time edge, slice end inside dead time, times going back
        write_reg(REG_WINDOW_DURATION, CFG_W'(10));
        write_reg(REG_MIN_DIGIS, CFG_W'(3));
        write_reg(REG_DEAD_TIME, CFG_W'(5));
        write_reg(REG_SEED_OFFSET, 32'h8000_0000);
        push_hit(TIME_W'(100), 1'b0);
        push_hit(TIME_W'(105), 1'b0);
        push_hit(TIME_W'(111), 1'b0);
        push_hit(TIME_W'(112), 1'b0);
        push_hit(TIME_W'(115), 1'b0);
        push_hit(TIME_W'(117), 1'b1);
        push_hit(TIME_W'(50), 1'b0);
        push_hit(TIME_W'(40), 1'b0);
        push_hit(TIME_W'(45), 1'b1);
        drain();

        // zero min_digis, maximum dead time, writes to unmapped indexes
        write_reg(REG_WINDOW_DURATION, '0);
        write_reg(REG_MIN_DIGIS, '0);
        write_reg(REG_DEAD_TIME, '1);
        write_reg(REG_SEED_OFFSET, 32'h7FFF_FFFF);
        write_reg(REG_UNMAPPED_TOP, '1);
        write_reg(REG_UNMAPPED_LOW, '0);
        push_hit(TIME_W'(7), 1'b0);
        push_hit(TIME_W'(8), 1'b0);
        push_hit(TIME_MAX, 1'b1);
        push_hit(TIME_W'(9), 1'b0);
        push_hit(TIME_W'(8), 1'b1);
        drain();

        phase_no = 0;
        while (hits_total < HIT_TARGET && phase_no < PHASE_CAP) begin
            random_phase(phase_no == 0);
            drain();
            phase_no++;
        end

        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial begin
        #8_000_000;
        $display("FAIL");
        $finish;
    end

endmodule

FILE: sim.f
src/sws_pkg.sv
src/sws_cell.sv
src/sws_ctrl.sv
src/sliding_window_seed_trigger.sv
test/sliding_window_seed_trigger_test.sv
